/* src/key_click_classifier_core_assert.svh */
// ----------------------------------------------------------------------------
// key_click_classifier_core_assert.svh
// Assertion macros shared by the key click classifier checker.
// ----------------------------------------------------------------------------
`ifndef KEY_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define KEY_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define KCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kcc assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define KCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kcc assertion failed");

`endif

/* src/kcc_pkg.sv */
// ----------------------------------------------------------------------------
// kcc_pkg
// Types, constants and helpers for the key click classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kcc_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int KEY_W     = 3;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 12;
    localparam int EN_W      = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 12;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Register reset values
    localparam logic [EN_W-1:0]  DBL_EN_RST = 4'd1;
    localparam logic [CNT_W-1:0] LONG_RST   = 12'd80;
    localparam logic [CNT_W-1:0] WINDOW_RST = 12'd25;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_SHORT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;

    localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;
    localparam logic [KEY_W-1:0] KEY_LAST = 3'(NUM_KEYS);

    typedef enum logic [6:0] {
        MODE_IDLE     = 7'b000_0001,
        MODE_DEBOUNCE = 7'b000_0010,
        MODE_HELD     = 7'b000_0100,
        MODE_WAIT_LNG = 7'b000_1000,
        MODE_WINDOW   = 7'b001_0000,
        MODE_SECOND   = 7'b010_0000,
        MODE_WAIT_DBL = 7'b100_0000
    } mode_t;

    typedef struct packed {
        logic [EN_W-1:0]  dbl_en;
        logic [CNT_W-1:0] long_ticks;
        logic [CNT_W-1:0] window_ticks;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
    } evt_t;

    // Double click allowed for this key under the enable mask
    function automatic logic dbl_allowed(input logic [EN_W-1:0] en,
                                         input logic [KEY_W-1:0] key);
        logic [1:0] idx;
        idx = 2'(key - 3'd1);
        if (key == KEY_NONE || key > 3'(EN_W))
            return 1'b0;
        return en[idx];
    endfunction

endpackage

/* src/key_click_classifier_core.sv */
// ----------------------------------------------------------------------------
// key_click_classifier_core
// Debounces key scan ticks and reports short, long and double presses.
// ----------------------------------------------------------------------------
// Takes one scan tick per clock cycle while the output is not stalled. The tick
// is captured in an input register, the state machine updates from it, and the
// event lands in an output register. A stalled output only holds new ticks back
// once both registers are full. Configuration writes take effect on the next
// processed tick.
`timescale 1ns / 1ps

module key_click_classifier_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kcc_pkg::S_DATA_W-1:0]  s_tdata,   // [2:0] pressed_key
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kcc_pkg::M_DATA_W-1:0]  m_tdata,   // [2:0] event_key, [4:3] event_kind
    input  logic                          cfg_we,
    input  logic [kcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kcc_pkg::CFG_W-1:0]     cfg_data
);
    import kcc_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [KEY_W-1:0]  in_key_reg;
    logic [KEY_W-1:0]  key_clean;
    logic              advance;
    evt_t              evt;
    logic              out_valid_reg;
    logic [KEY_W-1:0]  out_key_reg;
    logic [KIND_W-1:0] out_kind_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dbl_en       <= DBL_EN_RST;
            cfg_reg.long_ticks   <= LONG_RST;
            cfg_reg.window_ticks <= WINDOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DBL_EN: cfg_reg.dbl_en       <= cfg_data[EN_W-1:0];
                CFG_LONG:   cfg_reg.long_ticks   <= cfg_data;
                CFG_WINDOW: cfg_reg.window_ticks <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Process a held tick when the output slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Capture the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_key_reg <= s_tdata[KEY_W-1:0];
    end

    // Drop key numbers beyond the key count
    assign key_clean = (in_key_reg > KEY_LAST) ? KEY_NONE : in_key_reg;

    kcc_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .key   (key_clean),
        .cfg   (cfg_reg),
        .evt   (evt)
    );

    // Hold the event until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= evt.valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && evt.valid)
        begin
            out_key_reg  <= evt.key;
            out_kind_reg <= evt.kind;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_kind_reg, out_key_reg};

endmodule

/* src/kcc_fsm.sv */
// ----------------------------------------------------------------------------
// kcc_fsm
// Press classifier state machine: one scan tick per step, at most one event.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kcc_fsm (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [kcc_pkg::KEY_W-1:0] key,
    input  kcc_pkg::cfg_t         cfg,
    output kcc_pkg::evt_t         evt
);
    import kcc_pkg::*;

    mode_t            mode_reg, mode_next;
    logic [KEY_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    // Saturating tick counter
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 12'd1;

    // Next state and event for this tick
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        cnt_next  = cnt_reg;
        evt.valid = 1'b0;
        evt.key   = held_reg;
        evt.kind  = KIND_SHORT;
        unique case (mode_reg)
            MODE_DEBOUNCE:
            begin
                if (key == held_reg)
                begin
                    mode_next = MODE_HELD;
                    cnt_next  = '0;
                end
                else
                    mode_next = MODE_IDLE;
            end
            MODE_HELD:
            begin
                if (key == held_reg)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= cfg.long_ticks)
                    begin
                        evt.valid = 1'b1;
                        evt.kind  = KIND_LONG;
                        mode_next = MODE_WAIT_LNG;
                    end
                end
                else if (key == KEY_NONE)
                begin
                    cnt_next = '0;
                    if (dbl_allowed(cfg.dbl_en, held_reg))
                        mode_next = MODE_WINDOW;
                    else
                    begin
                        evt.valid = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                else
                begin
                    evt.valid = 1'b1;
                    held_next = key;
                    mode_next = MODE_DEBOUNCE;
                end
            end
            MODE_WAIT_LNG, MODE_WAIT_DBL:
            begin
                if (key == KEY_NONE)
                    mode_next = MODE_IDLE;
                else if (key != held_reg)
                begin
                    held_next = key;
                    mode_next = MODE_DEBOUNCE;
                end
            end
            MODE_WINDOW:
            begin
                if (key == KEY_NONE)
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= cfg.window_ticks)
                    begin
                        evt.valid = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                else if (key == held_reg)
                    mode_next = MODE_SECOND;
                else
                begin
                    evt.valid = 1'b1;
                    held_next = key;
                    mode_next = MODE_DEBOUNCE;
                end
            end
            MODE_SECOND:
            begin
                if (key == held_reg)
                begin
                    evt.valid = 1'b1;
                    evt.kind  = KIND_DOUBLE;
                    mode_next = MODE_WAIT_DBL;
                end
                else
                    mode_next = MODE_WINDOW;
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (key != KEY_NONE)
                begin
                    held_next = key;
                    mode_next = MODE_DEBOUNCE;
                end
            end
        endcase
    end

    // Advance the state only on a processed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            held_reg <= KEY_NONE;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

/* src/kcc_checker.sv */
// ----------------------------------------------------------------------------
// kcc_checker
// Port-level checks for the key click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_click_classifier_core_assert.svh"

module kcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kcc_pkg::M_DATA_W-1:0]  m_tdata
);
    import kcc_pkg::*;

    // Hold a stalled event
    `KCC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Events name a real key
    `KCC_ASSERT_NOW(a_key_range, m_tvalid, m_tdata[2:0] != KEY_NONE && m_tdata[2:0] <= KEY_LAST)

    // Only the three defined kinds and zero padding
    `KCC_ASSERT_NOW(a_kind_pad, m_tvalid, m_tdata[4:3] <= KIND_DOUBLE && m_tdata[7:5] == 3'd0)

    // An empty output slot never blocks the input
    `KCC_ASSERT_NOW(a_ready_free, !m_tvalid, s_tready)

endmodule

bind key_click_classifier_core kcc_checker u_kcc_checker (.*);

/* sim/key_click_classifier_core_test.sv */
// ----------------------------------------------------------------------------
// key_click_classifier_core_test
// Self-checking bench for the key click classifier core.
// ----------------------------------------------------------------------------
// Scan ticks go in as stream requests from a queue of pending ticks, with
// random gaps on the input side and random back-pressure on the output side.
// A local copy of the click state machine predicts the event for each
// accepted tick. Each event from the core is checked, field by field and in
// order, against that prediction. The settings are reprogrammed between
// phases, but only once the core has drained, and the extremes are included.
`timescale 1ns / 1ps

module key_click_classifier_core_test;
    import kcc_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LINES     = 40;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [KIND_W-1:0] kind;
    } click_event_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Pending scan ticks and predicted events
    logic [KEY_W-1:0] scan_ticks[$];
    click_event_t     pending_events[$];
    int               queued_ticks = 0;
    int               error_count  = 0;

    // Pacing controls shared between stimulus, driver and receiver
    bit               sender_gaps_on   = 1'b1;
    bit               receiver_gaps_on = 1'b1;
    bit               tick_taken       = 1'b0;
    int               gap_left         = 0;
    int               hold_left        = 0;
    int               hold_asks        = 0;
    int               hold_served      = 0;

    // Local copy of the click machine and its settings
    mode_t            track_mode   = MODE_IDLE;
    logic [KEY_W-1:0] track_key    = KEY_NONE;
    logic [CNT_W-1:0] track_count  = '0;
    logic [EN_W-1:0]  dbl_mask     = DBL_EN_RST;
    logic [CNT_W-1:0] long_limit   = LONG_RST;
    logic [CNT_W-1:0] window_limit = WINDOW_RST;

    key_click_classifier_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Pause length: mostly none or short, now and then long
    function automatic int pick_pause(input int zero_pct);
        if ($urandom_range(99) < zero_pct)
            return 0;
        if ($urandom_range(99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the click machine by one scan tick; return 1 when it reports
    function automatic bit classify_tick(input logic [KEY_W-1:0] raw,
                                         output click_event_t ev);
        logic [KEY_W-1:0] key;
        bit               fired;
        key   = (raw > KEY_LAST) ? KEY_NONE : raw;
        fired = 1'b0;
        ev    = '0;
        case (track_mode)
            MODE_DEBOUNCE:
            begin
                if (key == track_key)
                begin
                    track_mode  = MODE_HELD;
                    track_count = '0;
                end
                else
                    track_mode = MODE_IDLE;
            end
            MODE_HELD:
            begin
                if (key == track_key)
                begin
                    if (track_count != COUNT_MAX)
                        track_count++;
                    if (track_count >= long_limit)
                    begin
                        ev         = '{track_key, KIND_LONG};
                        fired      = 1'b1;
                        track_mode = MODE_WAIT_LNG;
                    end
                end
                else if (key == KEY_NONE)
                begin
                    track_count = '0;
                    if (dbl_allowed(dbl_mask, track_key))
                        track_mode = MODE_WINDOW;
                    else
                    begin
                        ev         = '{track_key, KIND_SHORT};
                        fired      = 1'b1;
                        track_mode = MODE_IDLE;
                    end
                end
                else
                begin
                    // Slide to another key: settle the old one first
                    ev         = '{track_key, KIND_SHORT};
                    fired      = 1'b1;
                    track_key  = key;
                    track_mode = MODE_DEBOUNCE;
                end
            end
            MODE_WAIT_LNG, MODE_WAIT_DBL:
            begin
                if (key == KEY_NONE)
                    track_mode = MODE_IDLE;
                else if (key != track_key)
                begin
                    track_key  = key;
                    track_mode = MODE_DEBOUNCE;
                end
            end
            MODE_WINDOW:
            begin
                if (key == KEY_NONE)
                begin
                    if (track_count != COUNT_MAX)
                        track_count++;
                    if (track_count >= window_limit)
                    begin
                        ev         = '{track_key, KIND_SHORT};
                        fired      = 1'b1;
                        track_mode = MODE_IDLE;
                    end
                end
                else if (key == track_key)
                    track_mode = MODE_SECOND;
                else
                begin
                    ev         = '{track_key, KIND_SHORT};
                    fired      = 1'b1;
                    track_key  = key;
                    track_mode = MODE_DEBOUNCE;
                end
            end
            MODE_SECOND:
            begin
                if (key == track_key)
                begin
                    ev         = '{track_key, KIND_DOUBLE};
                    fired      = 1'b1;
                    track_mode = MODE_WAIT_DBL;
                end
                else
                    track_mode = MODE_WINDOW;
            end
            default:
            begin
                track_mode = MODE_IDLE;
                if (key != KEY_NONE)
                begin
                    track_key  = key;
                    track_mode = MODE_DEBOUNCE;
                end
            end
        endcase
        return fired;
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        if (error_count < REPORT_LINES)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
        error_count++;
    endtask

    // Present scan tick requests; hold each until taken, then pause at random
    always @(negedge clk)
    begin : driver
        if (!s_tvalid || tick_taken)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (scan_ticks.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= S_DATA_W'(scan_ticks.pop_front());
                gap_left = pick_pause(sender_gaps_on ? 60 : 100);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Drive back-pressure on the event side, with a long hold-off on request
    always @(negedge clk)
    begin : receiver
        if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left   = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            hold_left = pick_pause(receiver_gaps_on ? 70 : 100);
            if (hold_left == 0)
                m_tready <= 1'b1;
            else
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
        end
    end

    // Check events against the oldest prediction, then predict for new ticks
    always @(posedge clk)
    begin : monitor
        click_event_t got;
        click_event_t want;
        click_event_t predicted;
        tick_taken <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.key  = m_tdata[KEY_W-1:0];
                got.kind = m_tdata[KEY_W +: KIND_W];
                if (pending_events.size() == 0)
                    report_mismatch("event with none predicted, key", got.key, 0);
                else
                begin
                    want = pending_events.pop_front();
                    if (got.key !== want.key)
                        report_mismatch("event_key", got.key, want.key);
                    if (got.kind !== want.kind)
                        report_mismatch("event_kind", got.kind, want.kind);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (classify_tick(s_tdata[KEY_W-1:0], predicted))
                    pending_events.push_back(predicted);
            end
        end
    end

    task automatic push_hold(input logic [KEY_W-1:0] key, input int count);
        repeat (count) scan_ticks.push_back(key);
        queued_ticks += count;
    endtask

    // Wait until every tick has gone in and every event has come out
    task automatic settle_block();
        while (scan_ticks.size() != 0 || s_tvalid || pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_DBL_EN: dbl_mask     = value[EN_W-1:0];
            CFG_LONG:   long_limit   = value;
            CFG_WINDOW: window_limit = value;
            default:    ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drain, reprogram every register and pick the pacing for the next phase
    task automatic program_settings(input logic [EN_W-1:0] dbl, input logic [CNT_W-1:0] lng,
                                    input logic [CNT_W-1:0] win);
        settle_block();
        write_reg(CFG_DBL_EN, {8'($urandom()), dbl});
        write_reg(CFG_LONG, lng);
        write_reg(CFG_WINDOW, win);
        sender_gaps_on   = ($urandom_range(3) != 0);
        receiver_gaps_on = ($urandom_range(3) != 0);
    endtask

    // Queue one well-formed press pattern with random timing, or some noise
    task automatic queue_gesture();
        int               pick;
        int               span_long;
        int               span_win;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] other;
        span_long = (long_limit > 30) ? 30 : int'(long_limit);
        span_win  = (window_limit > 20) ? 20 : int'(window_limit);
        key       = 3'($urandom_range(1, NUM_KEYS));
        other     = 3'($urandom_range(1, NUM_KEYS - 1));
        if (other >= key)
            other++;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            push_hold(key, $urandom_range(1, span_long + 1));
            push_hold(KEY_NONE, $urandom_range(1, span_win + 3));
        end
        else if (pick < 40)
        begin
            push_hold(key, span_long + 2 + $urandom_range(0, 3));
            push_hold(KEY_NONE, $urandom_range(1, 3));
        end
        else if (pick < 65)
        begin
            push_hold(key, $urandom_range(2, span_long + 1));
            push_hold(KEY_NONE, $urandom_range(1, span_win + 1));
            push_hold(key, $urandom_range(1, 4));
            push_hold(KEY_NONE, $urandom_range(1, 4));
        end
        else if (pick < 80)
        begin
            push_hold(key, $urandom_range(2, 5));
            push_hold(other, $urandom_range(1, 5));
            push_hold(KEY_NONE, $urandom_range(1, span_win + 2));
        end
        else
            repeat ($urandom_range(1, 6)) push_hold(3'($urandom_range(0, 7)), 1);
    endtask

    task automatic fill_gestures(input int target);
        int start;
        start = queued_ticks;
        while (queued_ticks - start < target)
            queue_gesture();
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: key 1 has double click, key 2 has not
        push_hold(1, 2);
        push_hold(KEY_NONE, 1);
        push_hold(1, 2);
        push_hold(2, 2);
        push_hold(KEY_NONE, 1);

        // Directed cases under small thresholds, double click on keys 1 and 3
        program_settings(4'b0101, 12'd3, 12'd2);
        push_hold(1, 2);
        push_hold(KEY_NONE, 3);
        push_hold(3, 5);
        push_hold(4, 2);
        push_hold(KEY_NONE, 1);
        push_hold(1, 2);
        push_hold(KEY_NONE, 1);
        push_hold(1, 1);
        push_hold(KEY_NONE, 3);
        push_hold(1, 2);
        push_hold(KEY_NONE, 1);
        push_hold(1, 2);
        push_hold(7, 1);
        push_hold(3, 2);
        push_hold(2, 1);
        push_hold(5, 1);
        push_hold(6, 1);
        push_hold(1, 2);
        push_hold(KEY_NONE, 1);
        push_hold(2, 2);
        push_hold(KEY_NONE, 1);

        // Lowest thresholds, no double click anywhere
        program_settings(4'h0, 12'd1, 12'd1);
        fill_gestures(50);

        repeat (3)
        begin
            program_settings(4'($urandom_range(15)), 12'($urandom_range(1, 24)),
                             12'($urandom_range(1, 12)));
            fill_gestures(50);
        end

        // Hold off the event side while short presses stream in back to back
        program_settings(4'h0, 12'd6, 12'd4);
        sender_gaps_on = 1'b0;
        hold_asks++;
        repeat (40)
        begin
            push_hold(3'($urandom_range(1, NUM_KEYS)), 2);
            push_hold(KEY_NONE, 1);
        end

        // Highest thresholds: presses settle by sliding and by a second press
        program_settings(4'hF, 12'd4095, 12'd4095);
        push_hold(1, 40);
        push_hold(KEY_NONE, 2);
        push_hold(2, 2);
        push_hold(KEY_NONE, 30);
        push_hold(3, 2);
        push_hold(KEY_NONE, 20);
        push_hold(3, 2);
        push_hold(KEY_NONE, 1);

        repeat (2)
        begin
            program_settings(4'($urandom_range(15)), 12'($urandom_range(1, 40)),
                             12'($urandom_range(1, 20)));
            fill_gestures(50);
        end

        settle_block();
        if (error_count == 0)
            $display("key_click_classifier_core_test: clean");
        else
            $display("key_click_classifier_core_test: errors");
        $finish;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("key_click_classifier_core_test: errors");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/kcc_pkg.sv
src/kcc_fsm.sv
src/key_click_classifier_core.sv
src/kcc_checker.sv
sim/key_click_classifier_core_test.sv
